@@ hdl/wsgs_pkg.sv @@
`default_nettype none

package wsgs_pkg;

    // field widths
    localparam int CNT_W   = 14;
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 18;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    // lane arithmetic: 17 bit interpolated value, 16 bit magnitude of the
    // difference, 30 bit product of magnitude and index
    localparam int LANE_W = 17;
    localparam int QUO_W  = 16;
    localparam int PROD_W = CNT_W + QUO_W;
    localparam int NUM_LANES = 4;

    // sequencer bit counter, covers both the multiply and the divide pass
    localparam int BIT_CNT_W = $clog2(QUO_W);

    localparam logic [CNT_W-1:0] MAX_STEPS = CNT_W'(10000);

    // action codes
    localparam logic [1:0] ACT_MOVE  = 2'd0;
    localparam logic [1:0] ACT_MAP   = 2'd1;
    localparam logic [1:0] ACT_UNMAP = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_END_W   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_END_H   = 3'd7;

    // sequencer to lane controls
    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic mul_bit;
    } lane_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/wsgs_lane.sv @@
`default_nettype none

module wsgs_lane (
    input  logic                                clk,
    input  wsgs_pkg::lane_ctrl_t                ctrl,
    input  logic [wsgs_pkg::LANE_W-1:0]         a,
    input  logic [wsgs_pkg::LANE_W-1:0]         b,
    input  logic [wsgs_pkg::CNT_W-1:0]          n,
    output logic [wsgs_pkg::LANE_W-1:0]         res
);
    import wsgs_pkg::*;

    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [QUO_W-1:0]  mag_reg, mag_next;
    logic              neg_reg, neg_next;

    logic [LANE_W:0]   diff;
    logic [LANE_W:0]   diff_abs;
    logic [CNT_W:0]    div_sh;
    logic              div_ge;
    logic [CNT_W:0]    div_sub;
    logic [PROD_W-1:0] mul_add;
    logic [LANE_W:0]   quo_ext;
    logic [LANE_W:0]   quo_s;
    logic [LANE_W:0]   sum;

    // sign and magnitude of end minus start
    assign diff     = {b[LANE_W-1], b} - {a[LANE_W-1], a};
    assign diff_abs = diff[LANE_W] ? (~diff + 1'b1) : diff;

    // shift-add multiply, index msb first
    assign mul_add = ctrl.mul_bit ? {{CNT_W{1'b0}}, mag_reg} : '0;

    // restoring divide, one quotient bit per cycle into the low end
    assign div_sh  = acc_reg[PROD_W-1:QUO_W-1];
    assign div_ge  = (div_sh >= {1'b0, n});
    assign div_sub = div_sh - {1'b0, n};

    always_comb
    begin
        acc_next = acc_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        if (ctrl.load)
        begin
            acc_next = '0;
            mag_next = diff_abs[QUO_W-1:0];
            neg_next = diff[LANE_W];
        end
        else if (ctrl.mul)
        begin
            acc_next = {acc_reg[PROD_W-2:0], 1'b0} + mul_add;
        end
        else if (ctrl.div)
        begin
            acc_next = {(div_ge ? div_sub[CNT_W-1:0] : div_sh[CNT_W-1:0]),
                        acc_reg[QUO_W-2:0], div_ge};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
    end

    // start plus signed quotient
    assign quo_ext = {2'b00, acc_reg[QUO_W-1:0]};
    assign quo_s   = neg_reg ? (~quo_ext + 1'b1) : quo_ext;
    assign sum     = {a[LANE_W-1], a} + quo_s;
    assign res     = sum[LANE_W-1:0];

endmodule

`default_nettype wire

@@ hdl/window_slide_geometry_stepper.sv @@
`default_nettype none

// Frame stepper for an animated window move and resize. Each accepted word
// (step_index, step_count) yields one result word: the rectangle for that
// step, interpolated between the start and end rectangles in the
// configuration registers, with an action code and a final-frame flag. Four
// lanes (x, y, w, h) run side by side; each multiplies the edge difference
// by the index with a shift-add over the 14 index bits and then divides by
// the count with a restoring divider that yields one quotient bit per cycle
// over 16 bits. An item occupies the block through its load, multiply,
// divide and finish steps; a step count of zero skips the arithmetic and
// goes from load straight to finish. A finished word waits in the output
// register while the next input word is accepted. Write configuration only
// while the block is idle.

module window_slide_geometry_stepper (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_write,
    input  logic [wsgs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wsgs_pkg::CFG_W-1:0]           cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [wsgs_pkg::CNT_W-1:0]           step_index,
    input  logic [wsgs_pkg::CNT_W-1:0]           step_count,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [wsgs_pkg::COORD_W-1:0]  frame_x,
    output logic signed [wsgs_pkg::COORD_W-1:0]  frame_y,
    output logic signed [wsgs_pkg::SIZE_W-1:0]   frame_w,
    output logic signed [wsgs_pkg::SIZE_W-1:0]   frame_h,
    output logic [1:0]                           action,
    output logic                                 final_frame
);
    import wsgs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    // configuration registers
    logic [COORD_W-1:0] start_x_reg, start_y_reg, start_w_reg, start_h_reg;
    logic [COORD_W-1:0] end_x_reg, end_y_reg, end_w_reg, end_h_reg;

    // sequencer
    state_t               state_reg, state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]     idx_sh_reg, idx_sh_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 fin_reg, fin_next;
    logic                 idx0_reg, idx0_next;
    logic                 cnt0_reg, cnt0_next;
    logic                 shown_reg, shown_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] frame_x_reg, frame_x_next;
    logic [COORD_W-1:0] frame_y_reg, frame_y_next;
    logic [SIZE_W-1:0]  frame_w_reg, frame_w_next;
    logic [SIZE_W-1:0]  frame_h_reg, frame_h_next;
    logic [1:0]         action_reg, action_next;
    logic               final_frame_reg, final_frame_next;

    logic             in_accept;
    logic             out_load;
    logic [CNT_W-1:0] cnt_sat;
    logic [CNT_W-1:0] idx_sat;
    lane_ctrl_t       lane_ctrl;

    logic [LANE_W-1:0] lane_a   [NUM_LANES];
    logic [LANE_W-1:0] lane_b   [NUM_LANES];
    logic [LANE_W-1:0] lane_res [NUM_LANES];

    logic [COORD_W-1:0] x_fin, y_fin;
    logic [SIZE_W-1:0]  right_s, right_e, bottom_s, bottom_e;
    logic [SIZE_W-1:0]  w_fin, h_fin;
    logic               shown_eff;
    logic               size_zero;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_w_reg <= '0;
            start_h_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
            end_w_reg   <= '0;
            end_h_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_START_X: start_x_reg <= cfg_data;
                CFG_START_Y: start_y_reg <= cfg_data;
                CFG_START_W: start_w_reg <= cfg_data;
                CFG_START_H: start_h_reg <= cfg_data;
                CFG_END_X:   end_x_reg   <= cfg_data;
                CFG_END_Y:   end_y_reg   <= cfg_data;
                CFG_END_W:   end_w_reg   <= cfg_data;
                CFG_END_H:   end_h_reg   <= cfg_data;
                default:     start_x_reg <= start_x_reg;
            endcase
        end
    end

    // handshakes
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    // count and index clamping
    assign cnt_sat = (step_count > MAX_STEPS) ? MAX_STEPS : step_count;
    assign idx_sat = (step_index > cnt_sat) ? cnt_sat : step_index;

    // lane operands: x and y sign extend, w and h zero extend
    assign lane_a[0] = {start_x_reg[COORD_W-1], start_x_reg};
    assign lane_b[0] = {end_x_reg[COORD_W-1], end_x_reg};
    assign lane_a[1] = {start_y_reg[COORD_W-1], start_y_reg};
    assign lane_b[1] = {end_y_reg[COORD_W-1], end_y_reg};
    assign lane_a[2] = {1'b0, start_w_reg};
    assign lane_b[2] = {1'b0, end_w_reg};
    assign lane_a[3] = {1'b0, start_h_reg};
    assign lane_b[3] = {1'b0, end_h_reg};

    assign lane_ctrl.load    = in_accept;
    assign lane_ctrl.mul     = (state_reg == ST_MUL);
    assign lane_ctrl.div     = (state_reg == ST_DIV);
    assign lane_ctrl.mul_bit = idx_sh_reg[CNT_W-1];

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        wsgs_lane u_lane (
            .clk  (clk),
            .ctrl (lane_ctrl),
            .a    (lane_a[g]),
            .b    (lane_b[g]),
            .n    (cnt_reg),
            .res  (lane_res[g])
        );
    end

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        idx_sh_next  = idx_sh_reg;
        cnt_next     = cnt_reg;
        fin_next     = fin_reg;
        idx0_next    = idx0_reg;
        cnt0_next    = cnt0_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    idx_sh_next  = idx_sat;
                    cnt_next     = cnt_sat;
                    fin_next     = (idx_sat == cnt_sat);
                    idx0_next    = (step_index == '0);
                    cnt0_next    = (step_count == '0);
                    bit_cnt_next = BIT_CNT_W'(CNT_W - 1);
                    state_next   = (step_count == '0) ? ST_FIN : ST_MUL;
                end
            end
            ST_MUL:
            begin
                idx_sh_next  = {idx_sh_reg[CNT_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    bit_cnt_next = BIT_CNT_W'(QUO_W - 1);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // held edges and sizes from the opposite edge
    assign x_fin = (start_x_reg == end_x_reg) ? start_x_reg : lane_res[0][COORD_W-1:0];
    assign y_fin = (start_y_reg == end_y_reg) ? start_y_reg : lane_res[1][COORD_W-1:0];

    assign right_s  = {{2{start_x_reg[COORD_W-1]}}, start_x_reg} + {2'b00, start_w_reg};
    assign right_e  = {{2{end_x_reg[COORD_W-1]}}, end_x_reg} + {2'b00, end_w_reg};
    assign bottom_s = {{2{start_y_reg[COORD_W-1]}}, start_y_reg} + {2'b00, start_h_reg};
    assign bottom_e = {{2{end_y_reg[COORD_W-1]}}, end_y_reg} + {2'b00, end_h_reg};

    assign w_fin = (right_s == right_e)
                 ? right_s - {{2{x_fin[COORD_W-1]}}, x_fin}
                 : {lane_res[2][LANE_W-1], lane_res[2]};
    assign h_fin = (bottom_s == bottom_e)
                 ? bottom_s - {{2{y_fin[COORD_W-1]}}, y_fin}
                 : {lane_res[3][LANE_W-1], lane_res[3]};

    assign shown_eff = shown_reg && !idx0_reg;
    assign size_zero = (w_fin == '0) || (h_fin == '0);

    // result word and mapped flag
    always_comb
    begin
        shown_next       = shown_reg;
        frame_x_next     = frame_x_reg;
        frame_y_next     = frame_y_reg;
        frame_w_next     = frame_w_reg;
        frame_h_next     = frame_h_reg;
        action_next      = action_reg;
        final_frame_next = final_frame_reg;
        out_valid_next   = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (cnt0_reg)
            begin
                frame_x_next     = end_x_reg;
                frame_y_next     = end_y_reg;
                frame_w_next     = {2'b00, end_w_reg};
                frame_h_next     = {2'b00, end_h_reg};
                final_frame_next = 1'b1;
                if ((end_w_reg == '0) || (end_h_reg == '0))
                begin
                    action_next = ACT_UNMAP;
                    shown_next  = 1'b0;
                end
                else
                begin
                    action_next = ACT_MAP;
                    shown_next  = 1'b1;
                end
            end
            else
            begin
                frame_x_next     = x_fin;
                frame_y_next     = y_fin;
                frame_w_next     = w_fin;
                frame_h_next     = h_fin;
                final_frame_next = fin_reg;
                if (size_zero)
                begin
                    action_next = shown_eff ? ACT_UNMAP : ACT_NONE;
                    shown_next  = 1'b0;
                end
                else
                begin
                    action_next = shown_eff ? ACT_MOVE : ACT_MAP;
                    shown_next  = 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            shown_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shown_reg     <= shown_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bit_cnt_reg     <= bit_cnt_next;
        idx_sh_reg      <= idx_sh_next;
        cnt_reg         <= cnt_next;
        fin_reg         <= fin_next;
        idx0_reg        <= idx0_next;
        cnt0_reg        <= cnt0_next;
        frame_x_reg     <= frame_x_next;
        frame_y_reg     <= frame_y_next;
        frame_w_reg     <= frame_w_next;
        frame_h_reg     <= frame_h_next;
        action_reg      <= action_next;
        final_frame_reg <= final_frame_next;
    end

    assign out_valid   = out_valid_reg;
    assign frame_x     = frame_x_reg;
    assign frame_y     = frame_y_reg;
    assign frame_w     = frame_w_reg;
    assign frame_h     = frame_h_reg;
    assign action      = action_reg;
    assign final_frame = final_frame_reg;

    // a fresh result word only comes out of the finish state
    a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result word appeared outside finish state");

    // zero count skips the arithmetic
    a_cnt0_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (step_count == '0)) |=> (state_reg == ST_FIN))
        else $error("zero count did not go straight to finish");

    // mapped flag agrees with the action just reported
    a_shown_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (((action_reg == ACT_MOVE) || (action_reg == ACT_MAP)) == shown_reg))
        else $error("mapped flag disagrees with action");

endmodule

`default_nettype wire

@@ test/tb_window_slide_geometry_stepper.sv @@
`timescale 1ns / 100ps

module tb_window_slide_geometry_stepper;

    import wsgs_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;

    // one frame word as seen on the output channel
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [SIZE_W-1:0]  w;
        logic signed [SIZE_W-1:0]  h;
        logic [1:0]                act;
        logic                      fin;
    } frame_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_W-1:0]            cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [CNT_W-1:0]            step_index = '0;
    logic [CNT_W-1:0]            step_count = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [COORD_W-1:0]   frame_x;
    logic signed [COORD_W-1:0]   frame_y;
    logic signed [SIZE_W-1:0]    frame_w;
    logic signed [SIZE_W-1:0]    frame_h;
    logic [1:0]                  action;
    logic                        final_frame;

    // predictor state: register mirror and mapped flag
    logic [CFG_W-1:0] geom [8];
    logic [CFG_W-1:0] next_geom [8];
    logic             mapped = 1'b0;

    frame_t frames_due [$];

    int  words_sent = 0;
    int  frames_seen = 0;
    int  frame_errors = 0;
    int  settings_applied = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  tx_gaps_on = 1'b1;
    bit  rx_gaps_on = 1'b1;

    window_slide_geometry_stepper u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .step_index  (step_index),
        .step_count  (step_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_x     (frame_x),
        .frame_y     (frame_y),
        .frame_w     (frame_w),
        .frame_h     (frame_h),
        .action      (action),
        .final_frame (final_frame)
    );

    always #6 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // expected frame for one accepted step, advances the mapped flag
    function automatic frame_t predict_frame(logic [CNT_W-1:0] idx_in,
                                             logic [CNT_W-1:0] cnt_in);
        longint sx, sy, sw, sh, ex, ey, ew, eh;
        longint i, n, x, y, w, h;
        frame_t f;
        sx = $signed(geom[CFG_START_X]);
        sy = $signed(geom[CFG_START_Y]);
        sw = geom[CFG_START_W];
        sh = geom[CFG_START_H];
        ex = $signed(geom[CFG_END_X]);
        ey = $signed(geom[CFG_END_Y]);
        ew = geom[CFG_END_W];
        eh = geom[CFG_END_H];
        i = idx_in;
        n = cnt_in;
        if (i == 0)
            mapped = 1'b0;
        if (n == 0)
        begin
            // jump straight to the end rectangle
            x = ex;
            y = ey;
            w = ew;
            h = eh;
            f.fin = 1'b1;
            if (ew == 0 || eh == 0)
            begin
                f.act = ACT_UNMAP;
                mapped = 1'b0;
            end
            else
            begin
                f.act = ACT_MAP;
                mapped = 1'b1;
            end
        end
        else
        begin
            if (n > MAX_STEPS)
                n = MAX_STEPS;
            if (i > n)
                i = n;
            f.fin = (i == n);
            x = sx + (ex - sx) * i / n;
            y = sy + (ey - sy) * i / n;
            w = sw + (ew - sw) * i / n;
            h = sh + (eh - sh) * i / n;
            // edges that stay put are pinned
            if (sx == ex)
                x = sx;
            if (sy == ey)
                y = sy;
            if (sx + sw == ex + ew)
                w = sx + sw - x;
            if (sy + sh == ey + eh)
                h = sy + sh - y;
            if (w == 0 || h == 0)
            begin
                if (mapped)
                begin
                    f.act = ACT_UNMAP;
                    mapped = 1'b0;
                end
                else
                    f.act = ACT_NONE;
            end
            else
            begin
                f.act = mapped ? ACT_MOVE : ACT_MAP;
                mapped = 1'b1;
            end
        end
        f.x = x[COORD_W-1:0];
        f.y = y[COORD_W-1:0];
        f.w = w[SIZE_W-1:0];
        f.h = h[SIZE_W-1:0];
        return f;
    endfunction

    // offer one step word and wait for it to be taken
    task automatic send_word(input logic [CNT_W-1:0] idx, input logic [CNT_W-1:0] cnt);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        step_index <= idx;
        step_count <= cnt;
        do
            @(posedge clk);
        while (in_stall);
        frames_due.push_back(predict_frame(idx, cnt));
        words_sent++;
    endtask

    // stop offering and wait until every frame has come back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all eight geometry registers from next_geom, block idle
    task automatic apply_geometry();
        settle();
        for (int r = 0; r < 8; r++)
        begin
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= next_geom[r];
            geom[r] = next_geom[r];
        end
        @(negedge clk);
        cfg_write <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic [CFG_W-1:0] pick_value(logic [CFG_W-1:0] partner);
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4, 5: return partner;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // random rectangles, often with equal or pinned edges
    task automatic random_geometry();
        longint edge_pos;
        longint need;
        next_geom[CFG_START_X] = pick_value(CFG_W'($urandom));
        next_geom[CFG_START_Y] = pick_value(CFG_W'($urandom));
        next_geom[CFG_START_W] = pick_value(CFG_W'($urandom));
        next_geom[CFG_START_H] = pick_value(CFG_W'($urandom));
        next_geom[CFG_END_X]   = pick_value(next_geom[CFG_START_X]);
        next_geom[CFG_END_Y]   = pick_value(next_geom[CFG_START_Y]);
        next_geom[CFG_END_W]   = pick_value(next_geom[CFG_START_W]);
        next_geom[CFG_END_H]   = pick_value(next_geom[CFG_START_H]);
        if ($urandom_range(0, 2) == 0)
        begin
            edge_pos = longint'($signed(next_geom[CFG_START_X])) + next_geom[CFG_START_W];
            need = edge_pos - longint'($signed(next_geom[CFG_END_X]));
            if (need >= 0 && need <= 65535)
                next_geom[CFG_END_W] = CFG_W'(need);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            edge_pos = longint'($signed(next_geom[CFG_START_Y])) + next_geom[CFG_START_H];
            need = edge_pos - longint'($signed(next_geom[CFG_END_Y]));
            if (need >= 0 && need <= 65535)
                next_geom[CFG_END_H] = CFG_W'(need);
        end
        apply_geometry();
    endtask

    // one animation: index walks from zero to the count, sometimes broken
    task automatic run_animation();
        int r;
        int count;
        int idx;
        r = $urandom_range(0, 19);
        if (r < 2)
            count = 0;
        else if (r < 12)
            count = $urandom_range(1, 12);
        else if (r < 16)
            count = $urandom_range(13, 64);
        else if (r < 18)
            count = $urandom_range(65, 10000);
        else
            count = $urandom_range(10001, 16383);
        if (count == 0)
            send_word(($urandom_range(0, 1) == 0) ? '0 : CNT_W'($urandom), '0);
        else
        begin
            idx = ($urandom_range(0, 7) == 0) ? $urandom_range(1, count) : 0;
            while (idx < count)
            begin
                send_word(CNT_W'(idx), CNT_W'(count));
                if (count <= 64)
                    idx++;
                else
                    idx += $urandom_range(1, count / 8);
            end
            if ($urandom_range(0, 7) == 0)
                send_word(CNT_W'($urandom_range(count, 16383)), CNT_W'(count));
            else
                send_word(CNT_W'(count), CNT_W'(count));
        end
    endtask

    task automatic run_mixed_traffic(input int target);
        int phase_end;
        while (words_sent < target)
        begin
            random_geometry();
            phase_end = words_sent + $urandom_range(60, 140);
            while (words_sent < phase_end && words_sent < target)
            begin
                if ($urandom_range(0, 6) == 0)
                    repeat ($urandom_range(1, 4))
                        send_word(CNT_W'($urandom), CNT_W'($urandom));
                else
                    run_animation();
            end
        end
    endtask

    task automatic test_reset_state();
        // all registers zero: empty rectangle everywhere
        send_word('0, '0);
        send_word(CNT_W'(3), CNT_W'(8));
    endtask

    task automatic test_pinned_extremes();
        // right and bottom edges pinned at the far corner, coordinates at limits
        next_geom[CFG_START_X] = 16'h8000;
        next_geom[CFG_START_W] = 16'hffff;
        next_geom[CFG_END_X]   = 16'h7fff;
        next_geom[CFG_END_W]   = 16'h0000;
        next_geom[CFG_START_Y] = 16'h7fff;
        next_geom[CFG_START_H] = 16'h0000;
        next_geom[CFG_END_Y]   = 16'h8000;
        next_geom[CFG_END_H]   = 16'hffff;
        apply_geometry();
        send_word('0, CNT_W'(10));
        send_word(CNT_W'(1), CNT_W'(10));
        send_word(CNT_W'(5), CNT_W'(10));
        send_word(CNT_W'(9), CNT_W'(10));
        send_word(CNT_W'(10), CNT_W'(10));
        send_word('1, '1);
        send_word(CNT_W'(1), '1);
        send_word(CNT_W'(9999), CNT_W'(10000));
        send_word(CNT_W'(12345), CNT_W'(10000));
        send_word('0, CNT_W'(1));
        send_word(CNT_W'(1), CNT_W'(1));
    endtask

    task automatic test_jump_to_end();
        // still x and y, sizes swap between full and empty
        next_geom[CFG_START_X] = 16'd100;
        next_geom[CFG_END_X]   = 16'd100;
        next_geom[CFG_START_Y] = 16'hfffb;
        next_geom[CFG_END_Y]   = 16'hfffb;
        next_geom[CFG_START_W] = 16'h0000;
        next_geom[CFG_END_W]   = 16'hffff;
        next_geom[CFG_START_H] = 16'hffff;
        next_geom[CFG_END_H]   = 16'h0000;
        apply_geometry();
        send_word('0, '0);
        send_word('0, CNT_W'(4));
        send_word(CNT_W'(2), CNT_W'(4));
        send_word(CNT_W'(4), CNT_W'(4));
        // nonzero end rectangle: a jump maps the window
        next_geom[CFG_END_H] = 16'd37;
        apply_geometry();
        send_word(CNT_W'(7), '0);
        send_word(CNT_W'(3), '0);
        send_word('1, '0);
    endtask

    task automatic test_output_backpressure();
        // receiver holds off while the sender keeps offering
        settle();
        hold_left = 300;
        repeat (12)
            send_word(CNT_W'($urandom_range(0, 20)), CNT_W'($urandom_range(0, 20)));
    endtask

    task automatic test_sender_pause();
        // drain in the middle of animations, mapped flag carries across
        repeat (3) run_animation();
        settle();
        repeat (3) run_animation();
    endtask

    task automatic test_back_to_back(input int target);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_mixed_traffic(target);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (rx_gaps_on && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // compare each delivered frame with the oldest prediction
    always @(posedge clk)
    begin
        frame_t got;
        frame_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.x   = frame_x;
            got.y   = frame_y;
            got.w   = frame_w;
            got.h   = frame_h;
            got.act = action;
            got.fin = final_frame;
            frames_seen++;
            if (frames_due.size() == 0)
            begin
                frame_errors++;
                if (frame_errors <= MAX_REPORTS)
                    $display("unexpected frame x=%0d y=%0d w=%0d h=%0d act=%0d fin=%0d",
                             got.x, got.y, got.w, got.h, got.act, got.fin);
            end
            else
            begin
                want = frames_due.pop_front();
                if (got !== want)
                begin
                    frame_errors++;
                    if (frame_errors <= MAX_REPORTS)
                    begin
                        $display("frame %0d exp x=%0d y=%0d w=%0d h=%0d act=%0d fin=%0d",
                                 frames_seen, want.x, want.y, want.w, want.h,
                                 want.act, want.fin);
                        $display("frame %0d got x=%0d y=%0d w=%0d h=%0d act=%0d fin=%0d",
                                 frames_seen, got.x, got.y, got.w, got.h,
                                 got.act, got.fin);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any word moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", quiet_cycles);
            $display("tb_window_slide_geometry_stepper: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        for (int r = 0; r < 8; r++)
        begin
            geom[r] = '0;
            next_geom[r] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_pinned_extremes();
        test_jump_to_end();
        run_mixed_traffic(1100);
        test_output_backpressure();
        test_sender_pause();
        test_back_to_back(1550);

        settle();
        $display("covered %0d step words and %0d frames over %0d geometry settings",
                 words_sent, frames_seen, settings_applied);
        $display("%0d frame errors, %0d frames never delivered",
                 frame_errors, frames_due.size());
        if (frame_errors == 0 && frames_due.size() == 0)
            $display("tb_window_slide_geometry_stepper: PASS");
        else
            $display("tb_window_slide_geometry_stepper: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/wsgs_pkg.sv
hdl/wsgs_lane.sv
hdl/window_slide_geometry_stepper.sv
test/tb_window_slide_geometry_stepper.sv
